@@ rtl/dmsm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmsm_pkg
// Shared types and constants for the dual motor speed model.
// ----------------------------------------------------------------------------
package dmsm_pkg;

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 31;
    localparam int AccW     = 58;

    localparam logic [16:0] SmoothOne  = 17'h10000;
    localparam logic [23:0] GainOne    = 24'h010000;
    localparam logic [30:0] MagMax     = 31'h7FFFFFFF;

    typedef enum logic [1:0] {
        F_SMOOTH   = 2'd0,
        F_GAIN     = 2'd1,
        F_MAXSPEED = 2'd2,
        F_MAXSTEP  = 2'd3
    } t_cfg_field;

    typedef struct packed {
        logic signed [31:0] left_target;
        logic signed [31:0] right_target;
    } t_in;

    typedef struct packed {
        logic signed [31:0] left_speed_out;
        logic signed [31:0] right_speed_out;
    } t_out;

    typedef struct packed {
        logic [16:0] smooth;
        logic [23:0] gain;
        logic [30:0] max_speed;
        logic [30:0] max_step;
    } t_chan_cfg;

    typedef enum logic [2:0] {
        OP_SMOOTH,
        OP_ACCUM,
        OP_GAIN,
        OP_CLAMP,
        OP_LIMIT
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SMOOTH,
        S_ACCUM,
        S_GAIN,
        S_CLAMP,
        S_LIMIT
    } t_state;

endpackage

@@ rtl/dual_motor_speed_model.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_motor_speed_model
// Smoothed, gained, clamped and slew-limited speed model for two motors.
// ----------------------------------------------------------------------------
// Channel | Direction | Signals
// in      | input     | i_in_valid, o_in_ready, i_in_data (t_in)
// out     | output    | o_out_valid, i_out_ready, o_out_data (t_out)
// cfg     | input     | i_cfg_we, i_cfg_idx, i_cfg_data
//
// From accept to result an item makes five passes of the shared multiply/saturate
// unit per motor, left then right.
// Reset clears both speeds and loads the default registers.
// A new item is taken once the sequencer is idle; a stalled result holds the
// last pass until the output register frees.
// ----------------------------------------------------------------------------
module dual_motor_speed_model (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  dmsm_pkg::t_in                  i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output dmsm_pkg::t_out                 o_out_data,
    input  logic                           i_cfg_we,
    input  logic [dmsm_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  logic [dmsm_pkg::CfgDataW-1:0]  i_cfg_data
);
    import dmsm_pkg::*;

    t_state                  r_state, n_state;
    logic                    r_chan, n_chan;
    logic                    r_out_valid;
    t_out                    r_out;
    t_in                     r_tgt;
    logic signed [31:0]      r_speed_l, r_speed_r;
    logic signed [AccW-1:0]  r_acc;
    t_chan_cfg               r_cfg_l, r_cfg_r;

    t_op                     op;
    t_chan_cfg               cfg_sel;
    logic signed [31:0]      prev;
    logic signed [31:0]      target;
    logic signed [AccW-1:0]  alu_res;
    logic                    in_acc;
    logic                    advance;
    logic                    out_free;
    logic                    finish;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign cfg_sel  = r_chan ? r_cfg_r : r_cfg_l;
    assign prev     = r_chan ? r_speed_r : r_speed_l;
    assign target   = r_chan ? r_tgt.right_target : r_tgt.left_target;

    dmsm_alu u_alu (
        .i_op     (op),
        .i_cfg    (cfg_sel),
        .i_prev   (prev),
        .i_target (target),
        .i_acc    (r_acc),
        .o_res    (alu_res)
    );

    always_comb begin
        n_state    = r_state;
        n_chan     = r_chan;
        op         = OP_SMOOTH;
        advance    = 1'b0;
        finish     = 1'b0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = S_SMOOTH;
                    n_chan  = 1'b0;
                end
            end
            S_SMOOTH: begin
                op      = OP_SMOOTH;
                n_state = S_ACCUM;
            end
            S_ACCUM: begin
                op      = OP_ACCUM;
                n_state = S_GAIN;
            end
            S_GAIN: begin
                op      = OP_GAIN;
                n_state = S_CLAMP;
            end
            S_CLAMP: begin
                op      = OP_CLAMP;
                n_state = S_LIMIT;
            end
            S_LIMIT: begin
                op = OP_LIMIT;
                if (!r_chan) begin
                    advance = 1'b1;
                    n_chan  = 1'b1;
                    n_state = S_SMOOTH;
                end else if (out_free) begin
                    advance = 1'b1;
                    finish  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_chan  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_chan  <= n_chan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out.left_speed_out  <= r_speed_l;
            r_out.right_speed_out <= alu_res[31:0];
        end
        if (in_acc) begin
            r_tgt <= i_in_data;
        end
        if (r_state != S_IDLE) begin
            r_acc <= alu_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_l <= '0;
            r_speed_r <= '0;
        end else if (advance) begin
            if (r_chan) begin
                r_speed_r <= alu_res[31:0];
            end else begin
                r_speed_l <= alu_res[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_l <= '{smooth: SmoothOne, gain: GainOne, max_speed: MagMax, max_step: MagMax};
            r_cfg_r <= '{smooth: SmoothOne, gain: GainOne, max_speed: MagMax, max_step: MagMax};
        end else if (i_cfg_we) begin
            if (i_cfg_idx[2]) begin
                case (t_cfg_field'(i_cfg_idx[1:0]))
                    F_SMOOTH:   r_cfg_r.smooth    <= i_cfg_data[16:0];
                    F_GAIN:     r_cfg_r.gain      <= i_cfg_data[23:0];
                    F_MAXSPEED: r_cfg_r.max_speed <= i_cfg_data;
                    F_MAXSTEP:  r_cfg_r.max_step  <= i_cfg_data;
                    default:    r_cfg_r           <= r_cfg_r;
                endcase
            end else begin
                case (t_cfg_field'(i_cfg_idx[1:0]))
                    F_SMOOTH:   r_cfg_l.smooth    <= i_cfg_data[16:0];
                    F_GAIN:     r_cfg_l.gain      <= i_cfg_data[23:0];
                    F_MAXSPEED: r_cfg_l.max_speed <= i_cfg_data;
                    F_MAXSTEP:  r_cfg_l.max_step  <= i_cfg_data;
                    default:    r_cfg_l           <= r_cfg_l;
                endcase
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_accept_starts_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_SMOOTH) && !r_chan)
        else $error("accepted item did not start on the left motor");

    a_result_after_right: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_LIMIT) && $past(r_chan))
        else $error("result raised outside the right motor step pass");

    a_speed_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_speed_l) && $stable(r_speed_r))
        else $error("motor speed changed outside a step pass");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !finish)
        else $error("result overwritten while waiting");

endmodule

@@ rtl/dmsm_alu.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmsm_alu
// Shared arithmetic unit: one multiplier plus saturate, clamp and step logic.
// ----------------------------------------------------------------------------
module dmsm_alu (
    input  dmsm_pkg::t_op                    i_op,
    input  dmsm_pkg::t_chan_cfg              i_cfg,
    input  logic signed [31:0]               i_prev,
    input  logic signed [31:0]               i_target,
    input  logic signed [dmsm_pkg::AccW-1:0] i_acc,
    output logic signed [dmsm_pkg::AccW-1:0] o_res
);
    import dmsm_pkg::*;

    function automatic logic signed [31:0] f_sat32(input logic signed [42:0] v);
        logic signed [42:0] hi;
        logic signed [42:0] lo;
        hi = 43'sd2147483647;
        lo = -43'sd2147483648;
        if (v > hi) begin
            f_sat32 = 32'sh7FFFFFFF;
        end else if (v < lo) begin
            f_sat32 = 32'sh80000000;
        end else begin
            f_sat32 = v[31:0];
        end
    endfunction

    logic        [16:0]           smooth_eff;
    logic signed [32:0]           diff;
    logic signed [32:0]           m_a;
    logic signed [24:0]           m_b;
    logic signed [57:0]           prod;
    logic signed [AccW-17:0]      sh;
    logic signed [42:0]           sum;
    logic signed [AccW-17:0]      vmax;
    logic signed [AccW-17:0]      vmin;
    logic signed [31:0]           clamped;
    logic signed [31:0]           cur;
    logic signed [32:0]           d;
    logic signed [32:0]           ms;
    logic signed [32:0]           up;
    logic signed [32:0]           dn;
    logic signed [31:0]           limited;

    assign smooth_eff = i_cfg.smooth[16] ? SmoothOne : i_cfg.smooth;
    assign diff       = {i_target[31], i_target} - {i_prev[31], i_prev};
    assign sh         = i_acc[AccW-1:16];
    assign cur        = i_acc[31:0];

    always_comb begin
        if (i_op == OP_GAIN) begin
            m_a = {cur[31], cur};
            m_b = {1'b0, i_cfg.gain};
        end else begin
            m_a = diff;
            m_b = {8'b0, smooth_eff};
        end
    end

    assign prod = m_a * m_b;

    assign sum = {{(43-32){i_prev[31]}}, i_prev} + {{(43-(AccW-16)){sh[AccW-17]}}, sh};

    assign vmax = signed'({{(AccW-16-31){1'b0}}, i_cfg.max_speed});
    assign vmin = -vmax;

    always_comb begin
        if (sh > vmax) begin
            clamped = vmax[31:0];
        end else if (sh < vmin) begin
            clamped = vmin[31:0];
        end else begin
            clamped = sh[31:0];
        end
    end

    assign d  = {cur[31], cur} - {i_prev[31], i_prev};
    assign ms = signed'({2'b0, i_cfg.max_step});
    assign up = {i_prev[31], i_prev} + ms;
    assign dn = {i_prev[31], i_prev} - ms;

    always_comb begin
        if (d > ms) begin
            limited = f_sat32({{10{up[32]}}, up});
        end else if (d < -ms) begin
            limited = f_sat32({{10{dn[32]}}, dn});
        end else begin
            limited = cur;
        end
    end

    always_comb begin
        case (i_op)
            OP_SMOOTH: o_res = prod[AccW-1:0];
            OP_GAIN:   o_res = prod[AccW-1:0];
            OP_ACCUM:  o_res = AccW'(f_sat32(sum));
            OP_CLAMP:  o_res = AccW'(clamped);
            OP_LIMIT:  o_res = AccW'(limited);
            default:   o_res = i_acc;
        endcase
    end

endmodule

@@ sim/tb_dual_motor_speed_model.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_motor_speed_model
// Drives target speed items into the two-motor speed model under random
// sender bursts and receiver stalls, and checks every result against a
// signed 64-bit model of the smoothing, gain, clamp and slew-limit chain.
// Register settings change between traffic phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_dual_motor_speed_model;
    import dmsm_pkg::*;

    localparam int ChanLeft   = 0;
    localparam int ChanRight  = 1;
    localparam int QuietLimit = 5000;
    localparam int LongHold   = 300;
    localparam int ItemCycles = 12;
    localparam int MaxReports = 60;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    t_in         i_in_data   = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out        o_out_data;
    logic        i_cfg_we    = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_idx  = '0;
    logic [CfgDataW-1:0] i_cfg_data = '0;

    t_chan_cfg          chan_cfg [2];
    logic signed [31:0] track_left;
    logic signed [31:0] track_right;
    t_out               pending_speeds [$];

    int errors      = 0;
    int burst_left  = 0;
    int tx_gap_max  = 0;
    int rx_mode     = 0;
    int hold_asked  = 0;
    int hold_seen   = 0;
    int hold_left   = 0;
    int rx_tick     = 0;
    int quiet_cycles = 0;

    dual_motor_speed_model u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint clamp_s32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic signed [31:0] next_speed(input logic signed [31:0] prev,
                                                      input logic signed [31:0] target,
                                                      input t_chan_cfg c);
        longint p, t, k, g, lim, stp, s, d;
        p   = longint'(prev);
        t   = longint'(target);
        k   = longint'((c.smooth > SmoothOne) ? SmoothOne : c.smooth);
        g   = longint'(c.gain);
        lim = longint'(c.max_speed);
        stp = longint'(c.max_step);
        s = clamp_s32(p + (((t - p) * k) >>> 16));
        s = clamp_s32((s * g) >>> 16);
        if (s > lim) s = lim;
        if (s < -lim) s = -lim;
        d = s - p;
        if (d > stp) begin
            s = clamp_s32(p + stp);
        end else if (d < -stp) begin
            s = clamp_s32(p - stp);
        end
        return s[31:0];
    endfunction

    function automatic t_chan_cfg make_cfg(input logic [16:0] smooth, input logic [23:0] gain,
                                           input logic [30:0] max_speed,
                                           input logic [30:0] max_step);
        t_chan_cfg c;
        c.smooth    = smooth;
        c.gain      = gain;
        c.max_speed = max_speed;
        c.max_step  = max_step;
        return c;
    endfunction

    function automatic t_chan_cfg pick_cfg();
        t_chan_cfg c;
        case ($urandom_range(0, 3))
            0:       c.smooth = 17'($urandom_range(0, 65536));
            1:       c.smooth = SmoothOne;
            2:       c.smooth = 17'($urandom_range(65537, 131071));
            default: c.smooth = 17'($urandom_range(0, 4096));
        endcase
        case ($urandom_range(0, 3))
            0:       c.gain = 24'($urandom_range(0, 131072));
            1:       c.gain = GainOne;
            2:       c.gain = 24'($urandom);
            default: c.gain = 24'($urandom_range(60000, 70000));
        endcase
        case ($urandom_range(0, 3))
            0:       c.max_speed = MagMax;
            1:       c.max_speed = 31'($urandom_range(0, 32'h1000000));
            2:       c.max_speed = 31'($urandom);
            default: c.max_speed = 31'($urandom_range(0, 16));
        endcase
        case ($urandom_range(0, 3))
            0:       c.max_step = MagMax;
            1:       c.max_step = 31'($urandom_range(0, 32'h100000));
            2:       c.max_step = 31'($urandom);
            default: c.max_step = 31'($urandom_range(0, 16));
        endcase
        return c;
    endfunction

    function automatic logic signed [31:0] pick_target(input logic signed [31:0] prev);
        logic signed [31:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom;
            4, 5, 6:    v = $signed($urandom_range(0, 32'h200000)) - 32'sh100000;
            7: begin
                case ($urandom_range(0, 3))
                    0:       v = 32'sh7FFFFFFF;
                    1:       v = 32'sh80000000;
                    2:       v = 32'sd0;
                    default: v = -32'sd1;
                endcase
            end
            default:    v = prev + ($signed($urandom_range(0, 32'h20000)) - 32'sh10000);
        endcase
        return v;
    endfunction

    function automatic logic [30:0] junk_bits(input bit junk, input logic [30:0] keep);
        logic [30:0] r;
        r = 31'($urandom);
        return junk ? (r & ~keep) : '0;
    endfunction

    task automatic reset_model();
        chan_cfg[ChanLeft]  = make_cfg(SmoothOne, GainOne, MagMax, MagMax);
        chan_cfg[ChanRight] = make_cfg(SmoothOne, GainOne, MagMax, MagMax);
        track_left  = '0;
        track_right = '0;
    endtask

    task automatic cfg_write(input int chan, input t_cfg_field f, input logic [30:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= {chan[0], f};
        i_cfg_data <= data;
        @(posedge i_clk);
        case (f)
            F_SMOOTH:   chan_cfg[chan].smooth    = data[16:0];
            F_GAIN:     chan_cfg[chan].gain      = data[23:0];
            F_MAXSPEED: chan_cfg[chan].max_speed = data[30:0];
            F_MAXSTEP:  chan_cfg[chan].max_step  = data[30:0];
            default: ;
        endcase
    endtask

    task automatic write_chan(input int chan, input t_chan_cfg c, input bit junk);
        cfg_write(chan, F_SMOOTH,   junk_bits(junk, 31'h1FFFF) | 31'(c.smooth));
        cfg_write(chan, F_GAIN,     junk_bits(junk, 31'hFFFFFF) | 31'(c.gain));
        cfg_write(chan, F_MAXSPEED, c.max_speed);
        cfg_write(chan, F_MAXSTEP,  c.max_step);
    endtask

    task automatic apply_settings(input t_chan_cfg left, input t_chan_cfg right, input bit junk);
        write_chan(ChanLeft, left, junk);
        write_chan(ChanRight, right, junk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_item(input logic signed [31:0] left, input logic signed [31:0] right);
        int gap;
        t_out want;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = (tx_gap_max == 0 || $urandom_range(0, 3) == 0) ? 0 :
                  $urandom_range(1, tx_gap_max);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in_data.left_target  <= left;
        i_in_data.right_target <= right;
        do @(posedge i_clk); while (!o_in_ready);
        burst_left--;
        track_left  = next_speed(track_left, left, chan_cfg[ChanLeft]);
        track_right = next_speed(track_right, right, chan_cfg[ChanRight]);
        want.left_speed_out  = track_left;
        want.right_speed_out = track_right;
        pending_speeds = {pending_speeds, want};
    endtask

    task automatic send_random(input int count);
        repeat (count) send_item(pick_target(track_left), pick_target(track_right));
    endtask

    task automatic drain_pipe();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (pending_speeds.size() != 0) @(posedge i_clk);
        repeat (ItemCycles) @(posedge i_clk);
    endtask

    task automatic test_directed_limits();
        tx_gap_max = 0;
        rx_mode    = 0;
        send_item(32'sh7FFFFFFF, 32'sh80000000);
        send_item(32'sh80000000, 32'sh7FFFFFFF);
        send_item(32'sd0, 32'sd0);
        send_item(-32'sd1, 32'sd1);
        send_item(32'sh7FFFFFFF, 32'sh7FFFFFFF);
        send_item(32'sh80000000, 32'sh80000000);
        drain_pipe();

        // hold the speed on the left, smoothing above one on the right
        apply_settings(make_cfg(17'd0, GainOne, MagMax, MagMax),
                       make_cfg(17'h1FFFF, GainOne, MagMax, MagMax), 1'b1);
        send_item(32'sh00050000, -32'sh00030000);
        send_item(32'sh80000000, 32'sh7FFFFFFF);
        send_item(32'sh12345678, 32'sh00010000);
        drain_pipe();

        // zero gain against full gain
        apply_settings(make_cfg(SmoothOne, 24'd0, MagMax, MagMax),
                       make_cfg(SmoothOne, 24'hFFFFFF, MagMax, MagMax), 1'b0);
        send_item(32'sh7FFFFFFF, 32'sh00000001);
        send_item(32'sh80000000, -32'sh00008000);
        send_item(32'sh00010000, 32'sh80000000);
        drain_pipe();

        // zero speed limit on the left, zero step on the right
        apply_settings(make_cfg(SmoothOne, GainOne, 31'd0, MagMax),
                       make_cfg(SmoothOne, GainOne, MagMax, 31'd0), 1'b0);
        send_item(32'sh7FFFFFFF, 32'sh7FFFFFFF);
        send_item(32'sh80000000, 32'sh80000000);
        send_item(32'sh00020000, -32'sh00020000);
        drain_pipe();

        apply_settings(make_cfg(17'h08000, GainOne, MagMax, 31'd1),
                       make_cfg(17'h08000, 24'h018000, 31'h00030000, 31'h00010000), 1'b1);
        send_item(32'sh7FFFFFFF, 32'sh7FFFFFFF);
        send_item(32'sh80000000, 32'sh80000000);
        send_item(-32'sd1, 32'sh00001234);
        send_item(32'sh00000003, -32'sh7FFFFFFF);
        drain_pipe();
    endtask

    task automatic test_random_traffic();
        t_chan_cfg left, right;
        for (int ph = 0; ph < 10; ph++) begin
            if (ph == 0) begin
                left  = make_cfg(17'h1FFFF, 24'hFFFFFF, MagMax, MagMax);
                right = make_cfg(17'd0, 24'd0, 31'd0, 31'd0);
            end else if (ph == 1) begin
                left  = make_cfg(17'd0, 24'd0, 31'd0, 31'd0);
                right = make_cfg(17'h1FFFF, 24'hFFFFFF, MagMax, MagMax);
            end else begin
                left  = pick_cfg();
                right = pick_cfg();
            end
            apply_settings(left, right, 1'($urandom_range(0, 1)));
            rx_mode    = ph % 4;
            tx_gap_max = (ph % 3 == 0) ? 0 : 8;
            if (ph == 5) hold_asked++;
            send_random(110);
            drain_pipe();
        end
    endtask

    task automatic test_output_stall_fill();
        apply_settings(pick_cfg(), pick_cfg(), 1'b0);
        tx_gap_max = 0;
        rx_mode    = 1;
        hold_asked++;
        send_random(80);
        drain_pipe();
    endtask

    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 1;
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (hold_seen != hold_asked) begin
            hold_seen   <= hold_asked;
            hold_left   <= LongHold;
            i_out_ready <= 1'b0;
        end else begin
            case (rx_mode)
                1:       i_out_ready <= ($urandom_range(0, 9) < 7);
                2:       i_out_ready <= ($urandom_range(0, 9) < 3);
                3:       i_out_ready <= ((rx_tick % 7) >= 3);
                default: i_out_ready <= 1'b1;
            endcase
        end
    end

    always @(posedge i_clk) begin : check_results
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_speeds.size() == 0) begin
                errors++;
                if (errors <= MaxReports)
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, o_out_data);
            end else begin
                want = pending_speeds.pop_front();
                if (o_out_data.left_speed_out !== want.left_speed_out) begin
                    errors++;
                    if (errors <= MaxReports)
                        $display("%0t: left_speed_out expected %h actual %h", $time,
                                 want.left_speed_out, o_out_data.left_speed_out);
                end
                if (o_out_data.right_speed_out !== want.right_speed_out) begin
                    errors++;
                    if (errors <= MaxReports)
                        $display("%0t: right_speed_out expected %h actual %h", $time,
                                 want.right_speed_out, o_out_data.right_speed_out);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QuietLimit) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        reset_model();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_limits();
        test_random_traffic();
        test_output_stall_fill();
        drain_pipe();
        repeat (2 * ItemCycles) @(posedge i_clk);
        if (pending_speeds.size() != 0) begin
            errors++;
            $display("%0t: %0d results never arrived", $time, pending_speeds.size());
        end
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
